[src/tcms_pkg.sv]
// Shared widths, word types and constants for the triangular complex matrix root block.
// No dependencies; every other file uses this package.
package tcms_pkg;

    localparam int WORD_BITS    = 32;
    localparam int FRAC_BITS    = 16;
    localparam int SIZE_BITS    = 4;
    localparam int OUT_IDX_BITS = 3;

    // multiplier takes a word or a sum of two words
    localparam int MUL_W  = WORD_BITS + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 2 * WORD_BITS;

    localparam int SQ_IN_W  = 2 * WORD_BITS;
    localparam int SQ_OUT_W = WORD_BITS;

    localparam int DIV_MAG_W = ACC_W;
    localparam int DIV_N     = DIV_MAG_W + FRAC_BITS;

    localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(8);

    typedef logic signed [WORD_BITS-1:0] word_t;

    typedef struct packed {
        word_t re;
        word_t im;
    } cplx_t;

    // request from the sequencer to the divider
    typedef struct packed {
        logic                 start;
        logic                 neg;
        logic [DIV_MAG_W-1:0] mag;
    } div_req_t;

endpackage

[src/tcms_if.sv]
// Channel interfaces: entry (input) and root (result) valid/ready channels.
// Depends on tcms_pkg.
interface tcms_entry_if;
    logic            valid;
    logic            ready;
    tcms_pkg::word_t entry_real;
    tcms_pkg::word_t entry_imag;

    modport source (output valid, entry_real, entry_imag, input ready);
    modport sink   (input valid, entry_real, entry_imag, output ready);
endinterface

interface tcms_root_if;
    logic                              valid;
    logic                              ready;
    logic [tcms_pkg::OUT_IDX_BITS-1:0] row_index;
    logic [tcms_pkg::OUT_IDX_BITS-1:0] col_index;
    tcms_pkg::word_t                   root_real;
    tcms_pkg::word_t                   root_imag;
    logic                              divide_fault;
    logic                              last_result;

    modport source (output valid, row_index, col_index, root_real, root_imag,
                    divide_fault, last_result, input ready);
    modport sink   (input valid, row_index, col_index, root_real, root_imag,
                    divide_fault, last_result, output ready);
endinterface

[src/triangular_complex_matrix_sqrt.sv]
// Top level of the upper-triangular complex matrix square root (column recurrence).
// Depends on tcms_pkg, tcms_if, tcms_sqrt and tcms_div.
//
// Usage: write matrix_size (n) while idle, then transfer the n(n+1)/2 upper entries in
// column-major order, one per cycle. After the last transfer the block computes the root
// and emits every root entry in the same order, with last_result on the final one.
// The compute phase runs one shared 33x33 multiplier, one bit-serial square root (three
// calls per diagonal entry) and one restoring divider (up to two calls per off-diagonal
// entry). Each result is held on the root channel until root.ready takes it, and the
// next result is not read out before then.
// No input transfer is taken from the last entry until the final result has left.
// A divisor of zero sets divide_fault on that entry; its value is zero.
module triangular_complex_matrix_sqrt #(
    parameter int MAX_SIZE = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [tcms_pkg::SIZE_BITS-1:0] cfg_wr_data,
    tcms_entry_if.sink                     entry,
    tcms_root_if.source                    root
);
    import tcms_pkg::*;

    localparam int DEPTH = MAX_SIZE * (MAX_SIZE + 1) / 2;
    localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(MAX_SIZE + 1);
    localparam int TRI_W = 2 * IDX_W;

    typedef enum logic [4:0] {
        S_LOAD, S_D_RD, S_D_SQA, S_D_SQB, S_D_SUM, S_D_M, S_D_RE, S_D_IM,
        S_O_INIT, S_O_RDX, S_O_RDY, S_O_CAPY, S_O_MUL, S_O_RDT, S_O_T, S_O_D,
        S_O_MP, S_O_DSR, S_O_DIVR, S_O_DSI, S_O_DIVI, S_O_WR,
        S_E_RD, S_E_LD, S_E_WAIT
    } state_t;

    // packed column-major position of entry (r, c)
    function automatic logic [POS_W-1:0] pos_f(input logic [IDX_W-1:0] r,
                                               input logic [IDX_W-1:0] c);
        logic [TRI_W-1:0] tri_v;
        tri_v = (TRI_W'(c) * (TRI_W'(c) + 1'b1)) >> 1;
        return POS_W'(tri_v + TRI_W'(r));
    endfunction

    // clamp a wide signed value to the word
    function automatic word_t sat_f(input logic signed [ACC_W:0] v);
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &v[ACC_W:WORD_BITS-1];
        hi_zeros = ~|v[ACC_W:WORD_BITS-1];
        if (hi_ones || hi_zeros)
            return v[WORD_BITS-1:0];
        else if (v[ACC_W])
            return {1'b1, {(WORD_BITS-1){1'b0}}};
        else
            return {1'b0, {(WORD_BITS-1){1'b1}}};
    endfunction

    // ---------------- state ----------------
    state_t                 state_reg;
    logic [SIZE_BITS-1:0]   matrix_size_reg;
    logic [CNT_W-1:0]       load_cnt_reg;
    logic [IDX_W-1:0]       i_reg, j_reg, k_reg;
    logic [2:0]             ph_reg;
    logic [POS_W-1:0]       ep_reg;

    word_t                  a_reg, b_reg;
    logic [SQ_OUT_W-1:0]    m_reg, re_reg;
    cplx_t                  x_reg, y_reg, t_reg;
    word_t                  nr_reg, ni_reg;
    logic signed [MUL_W-1:0] dr_reg, di_reg;
    logic signed [ACC_W-1:0] acc_r_reg, acc_i_reg;
    logic [ACC_W-1:0]       den_reg;
    word_t                  res_r_reg, res_i_reg;
    logic                   fault_cur_reg;
    logic [DEPTH-1:0]       fault_reg;

    logic                   sq_start_reg;
    logic [SQ_IN_W-1:0]     sq_rad_reg;
    div_req_t               div_req_reg;

    logic                   out_valid_reg;
    logic [OUT_IDX_BITS-1:0] out_row_reg, out_col_reg;
    word_t                  out_re_reg, out_im_reg;
    logic                   out_fault_reg, out_last_reg;

    logic signed [PROD_W-1:0] prod_reg;

    // ---------------- datapath wires ----------------
    logic [IDX_W-1:0]       n_act;
    logic [CNT_W-1:0]       total;
    logic [CNT_W-1:0]       lc_eff;

    cplx_t                  in_mem [DEPTH];
    cplx_t                  rt_mem [DEPTH];
    cplx_t                  in_q, rt_q;
    logic                   in_we, rt_we;
    logic [POS_W-1:0]       in_waddr, in_raddr, rt_waddr, rt_raddr;
    cplx_t                  rt_wdata;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [ACC_W-1:0] prod_fl, prod_lo;

    logic                   sq_done;
    logic [SQ_OUT_W-1:0]    sq_root;
    logic                   div_done;
    word_t                  div_quot;

    logic [WORD_BITS+1:0]   xr_sum, xi_sum;

    always_comb
    begin
        if (matrix_size_reg == '0)
            n_act = IDX_W'(1);
        else if (matrix_size_reg > SIZE_BITS'(MAX_SIZE))
            n_act = IDX_W'(MAX_SIZE);
        else
            n_act = IDX_W'(matrix_size_reg);
        total  = CNT_W'((TRI_W'(n_act) * (TRI_W'(n_act) + 1'b1)) >> 1);
        lc_eff = (load_cnt_reg >= total) ? '0 : load_cnt_reg;
    end

    // radicands of the diagonal real and imaginary roots
    always_comb
    begin
        xr_sum = {{2{a_reg[WORD_BITS-1]}}, a_reg} + {2'b00, m_reg};
        xi_sum = {2'b00, m_reg} - {{2{a_reg[WORD_BITS-1]}}, a_reg};
    end

    // ---------------- memories ----------------
    always_ff @(posedge clk)
    begin
        if (in_we)
            in_mem[in_waddr] <= '{re: entry.entry_real, im: entry.entry_imag};
        in_q <= in_mem[in_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rt_we)
            rt_mem[rt_waddr] <= rt_wdata;
        rt_q <= rt_mem[rt_raddr];
    end

    // ---------------- shared multiplier ----------------
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    assign prod_fl = ACC_W'(prod_reg >>> FRAC_BITS);
    assign prod_lo = ACC_W'(prod_reg);

    tcms_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start_reg),
        .radicand (sq_rad_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    tcms_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // ---------------- address, operand and write selection ----------------
    always_comb
    begin
        in_we    = 1'b0;
        in_waddr = lc_eff[POS_W-1:0];
        in_raddr = pos_f(j_reg, j_reg);
        rt_we    = 1'b0;
        rt_waddr = pos_f(i_reg, j_reg);
        rt_wdata = '{re: res_r_reg, im: res_i_reg};
        rt_raddr = ep_reg;
        mul_a    = '0;
        mul_b    = '0;
        // no transfer in the cycle of a size write
        entry.ready = (state_reg == S_LOAD) && !cfg_wr_en;

        case (state_reg)
            S_LOAD:
            begin
                in_we = entry.valid && !cfg_wr_en;
            end
            S_D_SQA:
            begin
                mul_a = MUL_W'(in_q.re);
                mul_b = MUL_W'(in_q.re);
            end
            S_D_SQB:
            begin
                mul_a = MUL_W'(b_reg);
                mul_b = MUL_W'(b_reg);
            end
            S_D_IM:
            begin
                rt_we    = sq_done;
                rt_waddr = pos_f(j_reg, j_reg);
                rt_wdata = '{re: word_t'(re_reg),
                             im: (b_reg > 0) ? word_t'(sq_root) : -word_t'(sq_root)};
            end
            S_O_RDX:
            begin
                rt_raddr = pos_f(i_reg, k_reg);
            end
            S_O_RDY:
            begin
                rt_raddr = pos_f(k_reg, j_reg);
            end
            S_O_MUL:
            begin
                case (ph_reg)
                    3'd0:
                    begin
                        mul_a = MUL_W'(x_reg.re);
                        mul_b = MUL_W'(y_reg.re);
                    end
                    3'd1:
                    begin
                        mul_a = MUL_W'(x_reg.im);
                        mul_b = MUL_W'(y_reg.im);
                    end
                    3'd2:
                    begin
                        mul_a = MUL_W'(x_reg.re);
                        mul_b = MUL_W'(y_reg.im);
                    end
                    3'd3:
                    begin
                        mul_a = MUL_W'(x_reg.im);
                        mul_b = MUL_W'(y_reg.re);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            S_O_RDT:
            begin
                in_raddr = pos_f(i_reg, j_reg);
                rt_raddr = pos_f(i_reg, i_reg);
            end
            S_O_T:
            begin
                rt_raddr = pos_f(j_reg, j_reg);
            end
            S_O_MP:
            begin
                case (ph_reg)
                    3'd0:
                    begin
                        mul_a = MUL_W'(nr_reg);
                        mul_b = dr_reg;
                    end
                    3'd1:
                    begin
                        mul_a = MUL_W'(ni_reg);
                        mul_b = di_reg;
                    end
                    3'd2:
                    begin
                        mul_a = MUL_W'(ni_reg);
                        mul_b = dr_reg;
                    end
                    3'd3:
                    begin
                        mul_a = MUL_W'(nr_reg);
                        mul_b = di_reg;
                    end
                    3'd4:
                    begin
                        mul_a = dr_reg;
                        mul_b = dr_reg;
                    end
                    3'd5:
                    begin
                        mul_a = di_reg;
                        mul_b = di_reg;
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            S_O_WR:
            begin
                rt_we = 1'b1;
            end
            default:
            begin
                rt_raddr = ep_reg;
            end
        endcase
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_LOAD;
            matrix_size_reg <= SIZE_RESET;
            load_cnt_reg    <= '0;
            i_reg           <= '0;
            j_reg           <= '0;
            k_reg           <= '0;
            ph_reg          <= '0;
            ep_reg          <= '0;
            a_reg           <= '0;
            b_reg           <= '0;
            m_reg           <= '0;
            re_reg          <= '0;
            x_reg           <= '0;
            y_reg           <= '0;
            t_reg           <= '0;
            nr_reg          <= '0;
            ni_reg          <= '0;
            dr_reg          <= '0;
            di_reg          <= '0;
            acc_r_reg       <= '0;
            acc_i_reg       <= '0;
            den_reg         <= '0;
            res_r_reg       <= '0;
            res_i_reg       <= '0;
            fault_cur_reg   <= 1'b0;
            fault_reg       <= '0;
            sq_start_reg    <= 1'b0;
            sq_rad_reg      <= '0;
            div_req_reg     <= '0;
            out_valid_reg   <= 1'b0;
            out_row_reg     <= '0;
            out_col_reg     <= '0;
            out_re_reg      <= '0;
            out_im_reg      <= '0;
            out_fault_reg   <= 1'b0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            sq_start_reg      <= 1'b0;
            div_req_reg.start <= 1'b0;

            if (cfg_wr_en)
            begin
                matrix_size_reg <= cfg_wr_data;
                load_cnt_reg    <= '0;
            end

            case (state_reg)
                S_LOAD:
                begin
                    if (entry.valid && !cfg_wr_en)
                    begin
                        if (lc_eff + 1'b1 == total)
                        begin
                            load_cnt_reg <= '0;
                            j_reg        <= '0;
                            state_reg    <= S_D_RD;
                        end
                        else
                        begin
                            load_cnt_reg <= lc_eff + 1'b1;
                        end
                    end
                end

                // diagonal: |t| by one root, then the two half-angle roots
                S_D_RD:
                begin
                    state_reg <= S_D_SQA;
                end
                S_D_SQA:
                begin
                    a_reg     <= in_q.re;
                    b_reg     <= in_q.im;
                    state_reg <= S_D_SQB;
                end
                S_D_SQB:
                begin
                    acc_r_reg <= prod_lo;
                    state_reg <= S_D_SUM;
                end
                S_D_SUM:
                begin
                    sq_rad_reg   <= acc_r_reg + prod_lo;
                    sq_start_reg <= 1'b1;
                    state_reg    <= S_D_M;
                end
                S_D_M:
                begin
                    if (sq_done)
                    begin
                        m_reg <= sq_root;
                        state_reg <= S_D_RE;
                        // shift the next radicand out of the adder on the following cycle
                    end
                    if (state_reg == S_D_M && sq_done)
                        sq_start_reg <= 1'b0;
                end
                S_D_RE:
                begin
                    if (!sq_start_reg && ph_reg == 3'd0)
                    begin
                        sq_rad_reg   <= SQ_IN_W'({xr_sum[WORD_BITS+1:1], {FRAC_BITS{1'b0}}});
                        sq_start_reg <= 1'b1;
                        ph_reg       <= 3'd1;
                    end
                    else if (sq_done)
                    begin
                        re_reg       <= sq_root;
                        sq_rad_reg   <= SQ_IN_W'({xi_sum[WORD_BITS+1:1], {FRAC_BITS{1'b0}}});
                        sq_start_reg <= 1'b1;
                        ph_reg       <= 3'd0;
                        state_reg    <= S_D_IM;
                    end
                end
                S_D_IM:
                begin
                    if (sq_done)
                    begin
                        fault_reg[pos_f(j_reg, j_reg)] <= 1'b0;
                        if (j_reg + 1'b1 == n_act)
                        begin
                            if (n_act == IDX_W'(1))
                            begin
                                i_reg     <= '0;
                                j_reg     <= '0;
                                ep_reg    <= '0;
                                state_reg <= S_E_RD;
                            end
                            else
                            begin
                                j_reg     <= IDX_W'(1);
                                i_reg     <= '0;
                                state_reg <= S_O_INIT;
                            end
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_D_RD;
                        end
                    end
                end

                // off-diagonal: dot product over k, then numerator times conj(d) / |d|^2
                S_O_INIT:
                begin
                    acc_r_reg <= '0;
                    acc_i_reg <= '0;
                    k_reg     <= i_reg + 1'b1;
                    ph_reg    <= '0;
                    state_reg <= ((i_reg + 1'b1) < j_reg) ? S_O_RDX : S_O_RDT;
                end
                S_O_RDX:
                begin
                    state_reg <= S_O_RDY;
                end
                S_O_RDY:
                begin
                    x_reg     <= rt_q;
                    state_reg <= S_O_CAPY;
                end
                S_O_CAPY:
                begin
                    y_reg     <= rt_q;
                    ph_reg    <= '0;
                    state_reg <= S_O_MUL;
                end
                S_O_MUL:
                begin
                    case (ph_reg)
                        3'd1:    acc_r_reg <= acc_r_reg + prod_fl;
                        3'd2:    acc_r_reg <= acc_r_reg - prod_fl;
                        3'd3:    acc_i_reg <= acc_i_reg + prod_fl;
                        3'd4:    acc_i_reg <= acc_i_reg + prod_fl;
                        default: acc_r_reg <= acc_r_reg;
                    endcase
                    if (ph_reg == 3'd4)
                    begin
                        ph_reg <= '0;
                        if ((k_reg + 1'b1) < j_reg)
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_O_RDX;
                        end
                        else
                        begin
                            state_reg <= S_O_RDT;
                        end
                    end
                    else
                    begin
                        ph_reg <= ph_reg + 1'b1;
                    end
                end
                S_O_RDT:
                begin
                    state_reg <= S_O_T;
                end
                S_O_T:
                begin
                    t_reg     <= in_q;
                    x_reg     <= rt_q;
                    state_reg <= S_O_D;
                end
                S_O_D:
                begin
                    dr_reg    <= MUL_W'(x_reg.re) + MUL_W'(rt_q.re);
                    di_reg    <= MUL_W'(x_reg.im) + MUL_W'(rt_q.im);
                    nr_reg    <= sat_f((ACC_W+1)'(t_reg.re) - (ACC_W+1)'(acc_r_reg));
                    ni_reg    <= sat_f((ACC_W+1)'(t_reg.im) - (ACC_W+1)'(acc_i_reg));
                    ph_reg    <= '0;
                    state_reg <= S_O_MP;
                end
                S_O_MP:
                begin
                    case (ph_reg)
                        3'd1:    acc_r_reg <= prod_lo;
                        3'd2:    acc_r_reg <= acc_r_reg + prod_lo;
                        3'd3:    acc_i_reg <= prod_lo;
                        3'd4:    acc_i_reg <= acc_i_reg - prod_lo;
                        3'd5:    den_reg   <= prod_lo;
                        3'd6:    den_reg   <= den_reg + prod_lo;
                        default: den_reg   <= den_reg;
                    endcase
                    if (ph_reg == 3'd6)
                    begin
                        ph_reg    <= '0;
                        state_reg <= S_O_DSR;
                    end
                    else
                    begin
                        ph_reg <= ph_reg + 1'b1;
                    end
                end
                S_O_DSR:
                begin
                    fault_cur_reg <= (den_reg == '0);
                    if (acc_r_reg == '0 || den_reg == '0)
                    begin
                        res_r_reg <= '0;
                        state_reg <= S_O_DSI;
                    end
                    else
                    begin
                        div_req_reg.start <= 1'b1;
                        div_req_reg.neg   <= acc_r_reg[ACC_W-1];
                        div_req_reg.mag   <= acc_r_reg[ACC_W-1] ? DIV_MAG_W'(-acc_r_reg)
                                                                : DIV_MAG_W'(acc_r_reg);
                        state_reg         <= S_O_DIVR;
                    end
                end
                S_O_DIVR:
                begin
                    if (div_done)
                    begin
                        res_r_reg <= div_quot;
                        state_reg <= S_O_DSI;
                    end
                end
                S_O_DSI:
                begin
                    if (acc_i_reg == '0 || den_reg == '0)
                    begin
                        res_i_reg <= '0;
                        state_reg <= S_O_WR;
                    end
                    else
                    begin
                        div_req_reg.start <= 1'b1;
                        div_req_reg.neg   <= acc_i_reg[ACC_W-1];
                        div_req_reg.mag   <= acc_i_reg[ACC_W-1] ? DIV_MAG_W'(-acc_i_reg)
                                                                : DIV_MAG_W'(acc_i_reg);
                        state_reg         <= S_O_DIVI;
                    end
                end
                S_O_DIVI:
                begin
                    if (div_done)
                    begin
                        res_i_reg <= div_quot;
                        state_reg <= S_O_WR;
                    end
                end
                S_O_WR:
                begin
                    fault_reg[pos_f(i_reg, j_reg)] <= fault_cur_reg;
                    if (i_reg == '0)
                    begin
                        if (j_reg + 1'b1 == n_act)
                        begin
                            i_reg     <= '0;
                            j_reg     <= '0;
                            ep_reg    <= '0;
                            state_reg <= S_E_RD;
                        end
                        else
                        begin
                            i_reg     <= j_reg;
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_O_INIT;
                        end
                    end
                    else
                    begin
                        i_reg     <= i_reg - 1'b1;
                        state_reg <= S_O_INIT;
                    end
                end

                // emit in column-major order
                S_E_RD:
                begin
                    state_reg <= S_E_LD;
                end
                S_E_LD:
                begin
                    out_valid_reg <= 1'b1;
                    out_row_reg   <= OUT_IDX_BITS'(i_reg);
                    out_col_reg   <= OUT_IDX_BITS'(j_reg);
                    out_re_reg    <= rt_q.re;
                    out_im_reg    <= rt_q.im;
                    out_fault_reg <= fault_reg[ep_reg];
                    out_last_reg  <= (CNT_W'(ep_reg) + 1'b1 == total);
                    state_reg     <= S_E_WAIT;
                end
                S_E_WAIT:
                begin
                    if (root.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            ep_reg <= ep_reg + 1'b1;
                            if (i_reg == j_reg)
                            begin
                                i_reg <= '0;
                                j_reg <= j_reg + 1'b1;
                            end
                            else
                            begin
                                i_reg <= i_reg + 1'b1;
                            end
                            state_reg <= S_E_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign root.valid        = out_valid_reg;
    assign root.row_index    = out_row_reg;
    assign root.col_index    = out_col_reg;
    assign root.root_real    = out_re_reg;
    assign root.root_imag    = out_im_reg;
    assign root.divide_fault = out_fault_reg;
    assign root.last_result  = out_last_reg;

`ifndef SYNTH
    a_no_load_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        root.valid |-> !entry.ready)
        else $error("entry ready while a result is pending");

    a_last_entry_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
        (entry.valid && entry.ready && !cfg_wr_en && (lc_eff + 1'b1 == total))
        |=> !entry.ready)
        else $error("load continued past the last entry");

    a_sqrt_done_awaited: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> (state_reg == S_D_M || state_reg == S_D_RE || state_reg == S_D_IM))
        else $error("square root finished outside a diagonal step");

    a_div_done_awaited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_O_DIVR || state_reg == S_O_DIVI))
        else $error("division finished outside an off-diagonal step");
`endif

endmodule

[src/tcms_sqrt.sv]
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on tcms_pkg.
module tcms_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tcms_pkg::SQ_IN_W-1:0]  radicand,
    output logic                          done,
    output logic [tcms_pkg::SQ_OUT_W-1:0] root
);
    import tcms_pkg::*;

    localparam int REM_W = SQ_OUT_W + 4;
    localparam int CNT_W = $clog2(SQ_OUT_W + 1);

    logic [SQ_IN_W-1:0]  rad_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [SQ_OUT_W-1:0] root_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [REM_W-1:0]    rem_sh;
    logic [REM_W-1:0]    trial;
    logic                fits;

    always_comb
    begin
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[SQ_IN_W-1 -: 2]};
        trial  = REM_W'({root_reg, 2'b01});
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SQ_OUT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[SQ_OUT_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[src/tcms_div.sv]
// Restoring divider: |num| * 2^FRAC / den, truncated, clamped to the word, signed.
// One quotient bit per cycle. Depends on tcms_pkg.
module tcms_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tcms_pkg::div_req_t             req,
    input  logic [tcms_pkg::DIV_MAG_W-1:0] den,
    output logic                           done,
    output tcms_pkg::word_t                quot
);
    import tcms_pkg::*;

    localparam int CNT_W = $clog2(DIV_N + 1);

    logic [DIV_N-1:0]     num_reg;
    logic [DIV_MAG_W:0]   rem_reg;
    logic [DIV_MAG_W-1:0] den_reg;
    logic [WORD_BITS:0]   q_reg;
    logic                 sat_reg;
    logic                 neg_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_MAG_W:0]   rem_sh;
    logic                 ge;
    logic [WORD_BITS:0]   lim;
    logic [WORD_BITS:0]   q_clamp;

    always_comb
    begin
        rem_sh  = {rem_reg[DIV_MAG_W-1:0], num_reg[DIV_N-1]};
        ge      = (rem_sh >= {1'b0, den_reg});
        lim     = neg_reg ? ((WORD_BITS+1)'(1) << (WORD_BITS - 1))
                          : (((WORD_BITS+1)'(1) << (WORD_BITS - 1)) - 1'b1);
        q_clamp = (sat_reg || (q_reg > lim)) ? lim : q_reg;
        quot    = neg_reg ? -word_t'(q_clamp[WORD_BITS-1:0]) : word_t'(q_clamp[WORD_BITS-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_N);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= {req.mag, {FRAC_BITS{1'b0}}};
            den_reg <= den;
            neg_reg <= req.neg;
            rem_reg <= '0;
            q_reg   <= '0;
            sat_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            // a bit shifted past the top already exceeds any limit
            sat_reg <= sat_reg | q_reg[WORD_BITS];
            q_reg   <= {q_reg[WORD_BITS-1:0], ge};
        end
    end

    assign done = done_reg;

endmodule
